/* src/rtdt_pkg.sv */
// rtdt_pkg: constants, types and arithmetic helpers for the PT100 resistance to
// temperature converter. Used by rtdt_isqrt, rtdt_poly and the top level.
package rtdt_pkg;

    localparam int RES_W           = 24;
    localparam int TEMP_W          = 24;
    localparam int RES_FRAC_BITS_D = 14;

    // Callendar-Van Dusen quadratic, Q12 / Q20
    localparam logic [23:0] A_Q12 = 24'd13860084;
    localparam logic [34:0] K_Q20 = 35'd18157160173;
    localparam logic [47:0] A2_Q24 = 48'(64'(A_Q12) * 64'(A_Q12));

    // Square root pipeline geometry
    localparam int RAD_W        = 48;
    localparam int ROOT_W       = 24;
    localparam int REM_W        = ROOT_W + 3;
    localparam int SQ_PER_STAGE = 3;
    localparam int SQ_STAGES    = ROOT_W / SQ_PER_STAGE;

    // Fallback polynomial, Horner form, Q16 r
    localparam int S_W    = 40;
    localparam int RQ_W   = 27;
    localparam int PROD_W = S_W + RQ_W + 1;
    localparam logic [RQ_W-1:0] R_CLAMP_Q16 = RQ_W'(1024 << 16);
    localparam logic signed [S_W-1:0] POLY_C5 = 40'sd11247348780;
    localparam logic signed [S_W-1:0] POLY_C4 = -40'sd2030799170;
    localparam logic signed [S_W-1:0] POLY_C3 = -40'sd339599558;
    localparam logic signed [S_W-1:0] POLY_C2 = 40'sd177701695;
    localparam logic signed [S_W-1:0] POLY_C1 = 40'sd149169583;
    localparam logic signed [S_W-1:0] POLY_C0 = -40'sd15861023;
    localparam int POLY_LAT = 8;

    localparam logic signed [S_W-1:0] T_MAX = 40'sd8388607;
    localparam logic signed [S_W-1:0] T_MIN = -40'sd8388608;

    typedef struct packed {
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
        logic [RAD_W-1:0]  x;
    } sq_state_t;

    // One digit of the restoring square root
    function automatic sq_state_t sq_step(input sq_state_t st);
        sq_state_t        o;
        logic [REM_W-1:0] trial;
        o.rem = {st.rem[REM_W-3:0], st.x[RAD_W-1 -: 2]};
        o.x = {st.x[RAD_W-3:0], 2'b00};
        trial = {1'b0, st.root, 2'b01};
        if (o.rem >= trial)
        begin
            o.rem = o.rem - trial;
            o.root = {st.root[ROOT_W-2:0], 1'b1};
        end
        else
        begin
            o.root = {st.root[ROOT_W-2:0], 1'b0};
        end
        return o;
    endfunction

    // Shift right with rounding half away from zero
    function automatic logic signed [PROD_W-1:0] rnd_shift(
        input logic signed [PROD_W-1:0] v, input int sh);
        logic [PROD_W-1:0] mag;
        mag = v[PROD_W-1] ? PROD_W'(-v) : PROD_W'(v);
        mag = (mag + (PROD_W'(1) << (sh - 1))) >> sh;
        return v[PROD_W-1] ? -$signed(mag) : $signed(mag);
    endfunction

endpackage

/* src/rtdt_isqrt.sv */
// rtdt_isqrt: pipelined floor square root, 48-bit radicand to 24-bit root,
// three digits per stage. Depends on rtdt_pkg.
module rtdt_isqrt (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic [rtdt_pkg::RAD_W-1:0] radicand,
    output logic                      out_valid,
    output logic [rtdt_pkg::ROOT_W-1:0] root
);
    import rtdt_pkg::*;

    sq_state_t st_reg [SQ_STAGES];
    sq_state_t st_next[SQ_STAGES];
    logic      v_reg  [SQ_STAGES];

    // digit stages
    always_comb
    begin
        sq_state_t t;
        for (int s = 0; s < SQ_STAGES; s++)
        begin
            if (s == 0)
            begin
                t.rem = '0;
                t.root = '0;
                t.x = radicand;
            end
            else
            begin
                t = st_reg[s-1];
            end
            for (int k = 0; k < SQ_PER_STAGE; k++)
                t = sq_step(t);
            st_next[s] = t;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int s = 0; s < SQ_STAGES; s++)
            st_reg[s] <= st_next[s];
    end

    // valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < SQ_STAGES; s++)
                v_reg[s] <= 1'b0;
        end
        else
        begin
            v_reg[0] <= in_valid;
            for (int s = 1; s < SQ_STAGES; s++)
                v_reg[s] <= v_reg[s-1];
        end
    end

    assign root      = st_reg[SQ_STAGES-1].root;
    assign out_valid = v_reg[SQ_STAGES-1];

endmodule

/* src/rtdt_poly.sv */
// rtdt_poly: fifth-order fallback polynomial, Horner form, one multiply per
// stage. Depends on rtdt_pkg.
module rtdt_poly #(
    parameter int RES_FRAC_BITS = rtdt_pkg::RES_FRAC_BITS_D
) (
    input  logic                           clk,
    input  logic [rtdt_pkg::RES_W-1:0]     resistance,
    output logic signed [rtdt_pkg::S_W-1:0] temp
);
    import rtdt_pkg::*;

    localparam int RQF_W = RES_W + 17;

    logic [RQF_W-1:0]          rq_full;
    logic [RQ_W-1:0]           rq_next;
    logic [RQ_W-1:0]           r_reg   [5];
    logic signed [PROD_W-1:0]  prod_reg[5];
    logic signed [S_W-1:0]     coef    [4];
    logic signed [S_W-1:0]     s0_reg;
    logic signed [S_W-1:0]     t_reg;

    assign coef[0] = POLY_C4;
    assign coef[1] = POLY_C3;
    assign coef[2] = POLY_C2;
    assign coef[3] = POLY_C1;

    // ohm to Q16 with rounding, clamped
    always_comb
    begin
        rq_full = (({1'b0, resistance, 16'b0}) + (RQF_W'(1) << (RES_FRAC_BITS - 1)))
                  >> RES_FRAC_BITS;
        rq_next = (rq_full > RQF_W'(R_CLAMP_Q16)) ? R_CLAMP_Q16 : rq_full[RQ_W-1:0];
    end

    // Horner steps
    always_ff @(posedge clk)
    begin
        r_reg[0]    <= rq_next;
        prod_reg[0] <= PROD_W'(POLY_C5) * $signed({1'b0, r_reg[0]});
        r_reg[1]    <= r_reg[0];
        for (int k = 1; k < 5; k++)
        begin
            prod_reg[k] <= PROD_W'(S_W'(rnd_shift(prod_reg[k-1], 26)) + coef[k-1])
                           * $signed({1'b0, r_reg[k]});
            if (k < 4)
                r_reg[k+1] <= r_reg[k];
        end
        s0_reg <= S_W'(rnd_shift(prod_reg[4], 26)) + POLY_C0;
        t_reg  <= S_W'(rnd_shift(PROD_W'(s0_reg), 4));
    end

    assign temp = t_reg;

endmodule

/* src/rtd_resistance_to_temperature_top.sv */
// PT100 resistance to temperature converter, top level.
// Depends on rtdt_pkg, rtdt_isqrt and rtdt_poly.
//
// Give a Q10.14 ohm value on resistance with start high; busy is never
// raised, so one transfer can go in every cycle. The Q11.12 degC value
// appears for one cycle with done high; the receiver must take it then.
// The latency is set by the eight-stage square root of the Callendar-Van
// Dusen branch; the Horner polynomial runs beside it.
module rtd_resistance_to_temperature_top #(
    parameter int RES_FRAC_BITS = rtdt_pkg::RES_FRAC_BITS_D
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [rtdt_pkg::RES_W-1:0]         resistance,
    output logic                               done,
    output logic signed [rtdt_pkg::TEMP_W-1:0] temperature,
    output logic                               used_polynomial,
    output logic                               saturated
);
    import rtdt_pkg::*;

    localparam logic [31:0] R0_RAW = 32'(100) << RES_FRAC_BITS;
    localparam int          LAT    = SQ_STAGES + 4;

    logic [RES_W-1:0]  r1_reg;
    logic              v1_reg, v2_reg, v3_reg;
    logic              ge2_reg;
    logic [58:0]       kd2_reg;
    logic [RES_W-1:0]  d1;
    logic [59:0]       term;
    logic              ok3_reg;
    logic [RAD_W-1:0]  rad3_reg;
    logic              ok_dly_reg[SQ_STAGES];
    logic signed [S_W-1:0] poly_t;
    logic signed [S_W-1:0] poly_dly_reg[2];
    logic              sq_valid;
    logic [ROOT_W-1:0] root;
    logic signed [S_W-1:0] t_sel;
    logic              done_reg, poly_reg, sat_reg;
    logic signed [TEMP_W-1:0] temp_reg;

    assign busy = 1'b0;
    assign d1   = RES_W'(32'(r1_reg) - R0_RAW);

    // front stages: capture, K*(R-R0), radicand
    always_ff @(posedge clk)
    begin
        r1_reg   <= resistance;
        ge2_reg  <= (32'(r1_reg) >= R0_RAW);
        kd2_reg  <= 59'(K_Q20) * 59'(d1);
        ok3_reg  <= ge2_reg && (term <= 60'(A2_Q24));
        rad3_reg <= A2_Q24 - term[RAD_W-1:0];
    end

    assign term = (60'(kd2_reg) + (60'(1) << (RES_FRAC_BITS - 5))) >> (RES_FRAC_BITS - 4);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= start && !busy;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    rtdt_isqrt u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v3_reg),
        .radicand  (rad3_reg),
        .out_valid (sq_valid),
        .root      (root)
    );

    rtdt_poly #(.RES_FRAC_BITS(RES_FRAC_BITS)) u_poly (
        .clk        (clk),
        .resistance (r1_reg),
        .temp       (poly_t)
    );

    // align branch flag and polynomial result with the root
    always_ff @(posedge clk)
    begin
        ok_dly_reg[0] <= ok3_reg;
        for (int s = 1; s < SQ_STAGES; s++)
            ok_dly_reg[s] <= ok_dly_reg[s-1];
        poly_dly_reg[0] <= poly_t;
        poly_dly_reg[1] <= poly_dly_reg[0];
    end

    // branch select and saturation
    always_comb
    begin
        if (ok_dly_reg[SQ_STAGES-1])
            t_sel = S_W'({1'b0, A_Q12}) - S_W'({1'b0, root});
        else
            t_sel = poly_dly_reg[1];
    end

    always_ff @(posedge clk)
    begin
        poly_reg <= !ok_dly_reg[SQ_STAGES-1];
        if (t_sel > T_MAX)
        begin
            temp_reg <= TEMP_W'(T_MAX);
            sat_reg  <= 1'b1;
        end
        else if (t_sel < T_MIN)
        begin
            temp_reg <= TEMP_W'(T_MIN);
            sat_reg  <= 1'b1;
        end
        else
        begin
            temp_reg <= TEMP_W'(t_sel);
            sat_reg  <= 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= sq_valid;
    end

    assign done            = done_reg;
    assign temperature     = temp_reg;
    assign used_polynomial = poly_reg;
    assign saturated       = sat_reg;

    // a saturated result sits on a limit
    a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
        done && saturated |-> temperature == TEMP_W'(T_MAX) ||
                              temperature == TEMP_W'(T_MIN))
        else $error("saturated result not at a limit");

    // the quadratic branch never yields a negative temperature
    a_quad_pos: assert property (@(posedge clk) disable iff (!rst_n)
        done && !used_polynomial |-> !temperature[TEMP_W-1])
        else $error("quadratic branch gave negative temperature");

    // fixed latency from transfer in to result strobe
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LAT))
        else $error("result without matching input transfer");

endmodule

/* tb/rtd_resistance_to_temperature_top_test.sv */
// Testbench for the PT100 resistance to temperature converter.
// Depends on rtdt_pkg and rtd_resistance_to_temperature_top; an internal scoreboard
// predicts each temperature in fixed point and checks every done strobe.
module rtd_resistance_to_temperature_top_test;
    import rtdt_pkg::*;

    typedef struct {
        logic signed [TEMP_W-1:0] temp;
        logic                     poly;
        logic                     sat;
    } temp_result_t;

    // Tracks expected conversions and compares them with the block's results
    class temp_scoreboard;
        temp_result_t pending_temps[$];
        int unsigned  mismatches = 0;

        static function longint rnd_half_away(longint v, int sh);
            longint unsigned mag;
            mag = (v < 0) ? longint'(-v) : longint'(v);
            mag = (mag + (64'd1 << (sh - 1))) >> sh;
            return (v < 0) ? -longint'(mag) : longint'(mag);
        endfunction

        static function longint unsigned floor_sqrt(longint unsigned x);
            longint unsigned root;
            longint unsigned bitv;
            root = 0;
            bitv = 64'd1 << 62;
            while (bitv > x)
                bitv >>= 2;
            while (bitv != 0)
            begin
                if (x >= root + bitv)
                begin
                    x = x - (root + bitv);
                    root = (root >> 1) + bitv;
                end
                else
                begin
                    root >>= 1;
                end
                bitv >>= 2;
            end
            return root;
        endfunction

        // Horner evaluation of the fifth-order fallback, r clamped to 1024 ohm
        static function longint fallback_temp(longint unsigned r_raw);
            longint unsigned rq;
            longint s;
            rq = ((r_raw << 16) + (64'd1 << (RES_FRAC_BITS_D - 1))) >> RES_FRAC_BITS_D;
            if (rq > 64'(1024) << 16)
                rq = 64'(1024) << 16;
            s = 64'sd11247348780;
            s = rnd_half_away(s * longint'(rq), 26) - 64'sd2030799170;
            s = rnd_half_away(s * longint'(rq), 26) - 64'sd339599558;
            s = rnd_half_away(s * longint'(rq), 26) + 64'sd177701695;
            s = rnd_half_away(s * longint'(rq), 26) + 64'sd149169583;
            s = rnd_half_away(s * longint'(rq), 26) - 64'sd15861023;
            return rnd_half_away(s, 4);
        endfunction

        static function temp_result_t convert(logic [RES_W-1:0] res);
            temp_result_t    o;
            longint unsigned r_raw, r0_raw, a_sq, d, term;
            longint          t;
            r_raw = 64'(res);
            r0_raw = 64'(100) << RES_FRAC_BITS_D;
            a_sq = 64'(A_Q12) * 64'(A_Q12);
            o.poly = 1'b1;
            o.sat = 1'b0;
            t = 0;
            if (r_raw >= r0_raw)
            begin
                d = r_raw - r0_raw;
                term = (64'(K_Q20) * d + (64'd1 << (RES_FRAC_BITS_D - 5)))
                       >> (RES_FRAC_BITS_D - 4);
                if (term <= a_sq)
                begin
                    t = longint'(64'(A_Q12)) - longint'(floor_sqrt(a_sq - term));
                    o.poly = 1'b0;
                end
            end
            if (o.poly)
                t = fallback_temp(r_raw);
            if (t > 64'sd8388607)
            begin
                t = 64'sd8388607;
                o.sat = 1'b1;
            end
            else if (t < -64'sd8388608)
            begin
                t = -64'sd8388608;
                o.sat = 1'b1;
            end
            o.temp = t[TEMP_W-1:0];
            return o;
        endfunction

        function void note_input(logic [RES_W-1:0] res);
            pending_temps.push_back(convert(res));
        endfunction

        function void check_result(logic signed [TEMP_W-1:0] temp, logic poly, logic sat);
            temp_result_t exp_r;
            if (pending_temps.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: temp=%0d poly=%b sat=%b", temp, poly, sat);
                return;
            end
            exp_r = pending_temps.pop_front();
            if (temp !== exp_r.temp || poly !== exp_r.poly || sat !== exp_r.sat)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: exp temp=%0d poly=%b sat=%b, got temp=%0d poly=%b sat=%b",
                             exp_r.temp, exp_r.poly, exp_r.sat, temp, poly, sat);
            end
        endfunction
    endclass

    localparam int WATCHDOG_LIMIT = 5000;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             start = 1'b0;
    logic [RES_W-1:0] resistance = '0;
    logic             busy;
    logic             done;
    logic signed [TEMP_W-1:0] temperature;
    logic             used_polynomial;
    logic             saturated;

    temp_scoreboard sb = new();
    int             idle_pct = 0;
    int             stall_count = 0;

    rtd_resistance_to_temperature_top dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .resistance(resistance),
        .done(done),
        .temperature(temperature),
        .used_polynomial(used_polynomial),
        .saturated(saturated)
    );

    always #4 clk = ~clk;

    // Monitor: note accepted transfers, check results, run the watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
                sb.note_input(resistance);
            if (done)
                sb.check_result(temperature, used_polynomial, saturated);
            if ((start && !busy) || done)
                stall_count <= 0;
            else
                stall_count <= stall_count + 1;
            if (stall_count >= WATCHDOG_LIMIT)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // One input transfer, with a random gap before it
    task automatic send_resistance(logic [RES_W-1:0] r);
        if ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        start <= 1'b1;
        resistance <= r;
        @(negedge clk);
        while (busy)
            @(negedge clk);
        @(posedge clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (sb.pending_temps.size() != 0)
            @(posedge clk);
    endtask

    // Mostly the working range, with full-scale noise on top
    function automatic logic [RES_W-1:0] random_resistance();
        int sel;
        sel = $urandom_range(9);
        if (sel < 5)
            return RES_W'($urandom_range(50 << 14, 800 << 14));
        else if (sel < 7)
            return RES_W'($urandom_range(95 << 14, 105 << 14));
        else
            return RES_W'($urandom);
    endfunction

    initial
    begin
        longint unsigned r0, dbound;
        r0 = 64'(100) << RES_FRAC_BITS_D;
        dbound = ((64'(A_Q12) * 64'(A_Q12)) << 10) / 64'(K_Q20);
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extremes, R0 edge, radicand sign change, clamp region
        send_resistance('0);
        send_resistance('1);
        send_resistance(RES_W'(r0));
        send_resistance(RES_W'(r0 - 1));
        send_resistance(RES_W'(r0 + 1));
        send_resistance(RES_W'(r0 + dbound - 1));
        send_resistance(RES_W'(r0 + dbound));
        send_resistance(RES_W'(r0 + dbound + 1));
        send_resistance(RES_W'(r0 + dbound + 2));
        send_resistance(RES_W'(18 << 14));
        send_resistance(RES_W'(1000 << 14));
        send_resistance(24'haaaaaa);
        send_resistance(24'h555555);
        send_resistance(24'd1);
        drain();

        // Random phases: light sender idling, heavy idling, then none
        for (int ph = 0; ph < 3; ph++)
        begin
            idle_pct = (ph == 0) ? 17 : (ph == 1) ? 73 : 0;
            for (int i = 0; i < 480; i++)
            begin
                if (i == 240)
                    drain();
                send_resistance(random_resistance());
            end
        end

        drain();
        repeat (20) @(posedge clk);
        if (sb.mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule

/* rtd_resistance_to_temperature_top.f */
src/rtdt_pkg.sv
src/rtdt_isqrt.sv
src/rtdt_poly.sv
src/rtd_resistance_to_temperature_top.sv
tb/rtd_resistance_to_temperature_top_test.sv
